// ===== sv/gzie_pkg.sv =====
// ----------------------------------------------------------------------------
// gzie_pkg
// Types, register codes and helpers shared by the glyph row expander modules.
// ----------------------------------------------------------------------------
package gzie_pkg;

   localparam int ROW_W    = 16;
   localparam int LINE_W   = 64;
   localparam int INDENT_W = 4;
   localparam int ZOOM_W   = 3;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [INDENT_W-1:0] LAST_ROW = 4'd15;

   localparam logic [1:0] REG_ITALIC_MODE = 2'd0;
   localparam logic [1:0] REG_ZOOM_X      = 2'd1;
   localparam logic [1:0] REG_ZOOM_Y      = 2'd2;

   typedef struct packed {
      logic                italic_mode;
      logic [ZOOM_W-1:0]   zoom_x;
      logic [ZOOM_W-1:0]   zoom_y;
   } cfg_type;

   typedef struct packed {
      logic [LINE_W-1:0]   line_pixels;
      logic [INDENT_W-1:0] indent_count;
      logic                last_row;
      logic [1:0]          lines_m1;
   } entry_type;

   // clamp a zoom register to 1..4, returned as count minus one
   function automatic logic [1:0] zoom_m1(input logic [ZOOM_W-1:0] z);
      logic [1:0] r;
      case (z)
         3'd0, 3'd1: r = 2'd0;
         3'd2:       r = 2'd1;
         3'd3:       r = 2'd2;
         default:    r = 2'd3;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/glyph_row_zoom_italic_expander_core.sv =====
// ----------------------------------------------------------------------------
// glyph_row_zoom_italic_expander_core
// Expands 16-pixel glyph rows into zoomed, optionally italic scan lines.
// ----------------------------------------------------------------------------
// Each request is one glyph row and yields zoom_y result lines (1 to 4), one
// per cycle while rsp_ready is high; the line counter in the back part sets
// the sustained rate of the result port.
// The front part widens a row in the cycle it is taken and places it in a
// QUEUE_DEPTH-entry queue, so new requests are accepted while earlier lines
// are still being delivered. Registers: italic_mode at 0x0, zoom_x at 0x4,
// zoom_y at 0x8; write them only while no request is in flight.
// ----------------------------------------------------------------------------
module glyph_row_zoom_italic_expander_core import gzie_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ROW_W-1:0]    req_row_bits,
   input  logic                req_glyph_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LINE_W-1:0]   rsp_line_pixels,
   output logic [INDENT_W-1:0] rsp_indent_count,
   output logic                rsp_row_done,
   output logic                rsp_glyph_done
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;
   logic       q_full;
   logic       q_push;
   logic       q_pop;
   logic       q_valid;
   entry_type  q_entry;
   entry_type  q_data;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign wr_en     = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_ITALIC_MODE: cfg_in.italic_mode = pwdata[0];
            REG_ZOOM_X:      cfg_in.zoom_x      = pwdata[ZOOM_W-1:0];
            REG_ZOOM_Y:      cfg_in.zoom_y      = pwdata[ZOOM_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ITALIC_MODE: prdata = {{(DATA_W-1){1'b0}}, cfg_ff.italic_mode};
         REG_ZOOM_X:      prdata = {{(DATA_W-ZOOM_W){1'b0}}, cfg_ff.zoom_x};
         REG_ZOOM_Y:      prdata = {{(DATA_W-ZOOM_W){1'b0}}, cfg_ff.zoom_y};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.italic_mode <= 1'b0;
         cfg_ff.zoom_x      <= 3'd1;
         cfg_ff.zoom_y      <= 3'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gzie_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_row_bits    (req_row_bits),
      .req_glyph_start (req_glyph_start),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (q_entry)
   );

   gzie_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   gzie_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_line_pixels  (rsp_line_pixels),
      .rsp_indent_count (rsp_indent_count),
      .rsp_row_done     (rsp_row_done),
      .rsp_glyph_done   (rsp_glyph_done)
   );

endmodule

// ===== sv/gzie_front.sv =====
// ----------------------------------------------------------------------------
// gzie_front
// Accepts glyph rows, tracks the row number and widens each row into a
// queue entry carrying the line, indent, flags and line count.
// ----------------------------------------------------------------------------
module gzie_front import gzie_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [ROW_W-1:0]    req_row_bits,
   input  logic                req_glyph_start,
   input  logic                q_full,
   output logic                q_push,
   output entry_type           q_entry
);

   logic [INDENT_W-1:0] row_ff;
   logic [INDENT_W-1:0] row_in;
   logic [INDENT_W-1:0] row_cur;
   logic [1:0]          zx_m1;
   logic [LINE_W-1:0]   line;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign row_cur   = req_glyph_start ? '0 : row_ff;
   assign zx_m1     = zoom_m1(cfg.zoom_x);

   always_comb begin
      line = '0;
      for (int c = 0; c < ROW_W; c++) begin
         case (zx_m1)
            2'd0:    line[LINE_W-1-c]     = req_row_bits[ROW_W-1-c];
            2'd1:    line[LINE_W-1-2*c -: 2] = {2{req_row_bits[ROW_W-1-c]}};
            2'd2:    line[LINE_W-1-3*c -: 3] = {3{req_row_bits[ROW_W-1-c]}};
            default: line[LINE_W-1-4*c -: 4] = {4{req_row_bits[ROW_W-1-c]}};
         endcase
      end
   end

   always_comb begin
      q_entry.line_pixels  = line;
      q_entry.indent_count = cfg.italic_mode ? (LAST_ROW - row_cur) : '0;
      q_entry.last_row     = (row_cur == LAST_ROW);
      q_entry.lines_m1     = zoom_m1(cfg.zoom_y);
   end

   // advance the row counter, wrapping after row fifteen
   assign row_in = q_push ? row_cur + 1'b1 : row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
      end
   end

endmodule

// ===== sv/gzie_queue.sv =====
// ----------------------------------------------------------------------------
// gzie_queue
// Short first-in first-out queue of widened rows between front and back.
// ----------------------------------------------------------------------------
module gzie_queue import gzie_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      pop_valid,
   output entry_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_pop;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== sv/gzie_back.sv =====
// ----------------------------------------------------------------------------
// gzie_back
// Takes widened rows from the queue and presents each as repeated scan
// lines on a registered result port, flagging row and glyph ends.
// ----------------------------------------------------------------------------
module gzie_back import gzie_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  entry_type           q_data,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LINE_W-1:0]   rsp_line_pixels,
   output logic [INDENT_W-1:0] rsp_indent_count,
   output logic                rsp_row_done,
   output logic                rsp_glyph_done
);

   entry_type  cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] line_ff, line_in;
   logic       last;
   logic       fire;
   logic       take;

   assign last  = (line_ff == cur_ff.lines_m1);
   assign fire  = cur_valid_ff && rsp_ready;
   assign take  = !cur_valid_ff || (fire && last);
   assign q_pop = take && q_valid;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      line_in      = line_ff;
      if (take) begin
         cur_in       = q_data;
         cur_valid_in = q_valid;
         line_in      = '0;
      end else if (fire) begin
         line_in = line_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         line_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         line_ff      <= line_in;
      end
   end

   assign rsp_valid        = cur_valid_ff;
   assign rsp_line_pixels  = cur_ff.line_pixels;
   assign rsp_indent_count = cur_ff.indent_count;
   assign rsp_row_done     = last;
   assign rsp_glyph_done   = last && cur_ff.last_row;

endmodule
